### rtl/core/afrp_pkg.sv
`timescale 1ns / 1ps
// Package for the audio frame ring packetizer: ring geometry, field widths,
// register indexes and reset values. No dependencies.
package afrp_pkg;

	localparam int unsigned RING_FRAMES = 1024;
	localparam int unsigned PTR_W = $clog2(RING_FRAMES);
	// common width for comparing ring counts against 10-bit registers
	localparam int unsigned CNT_W = (PTR_W > 10) ? PTR_W : 10;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned FRAME_W  = 2 * WORD_W;
	localparam int unsigned SAMPLE_W = 24;
	localparam int unsigned SHIFT    = 8;
	localparam int unsigned THR_W    = 10;
	localparam int unsigned REC_W    = 10;
	localparam int unsigned FPP_W    = 8;
	localparam int unsigned IDX_W    = 2;
	localparam int unsigned CFG_W    = 10;

	localparam logic [IDX_W-1:0] REG_OVERRUN_THRESHOLD = 2'd0;
	localparam logic [IDX_W-1:0] REG_RECOVER_FRAMES    = 2'd1;
	localparam logic [IDX_W-1:0] REG_FRAMES_PER_PACKET = 2'd2;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 10'd384;
	localparam logic [REC_W-1:0] RECOVER_RESET   = 10'd192;
	localparam logic [FPP_W-1:0] FPP_RESET       = 8'd240;

	localparam logic OP_CAPTURE = 1'b0;
	localparam logic OP_READ    = 1'b1;

endpackage

### rtl/core/afrp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the packetizer input and result items.
// Depends on afrp_pkg for field widths.
interface afrp_in_if import afrp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [WORD_W-1:0] left_word;
	logic [WORD_W-1:0] right_word;

	modport source (output valid, op, left_word, right_word, input ready);
	modport sink   (input valid, op, left_word, right_word, output ready);
endinterface

interface afrp_out_if import afrp_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic [FPP_W-1:0]           frame_slot;
	logic                       packet_last;
	logic [WORD_W-1:0]          packet_sequence;
	logic                       overrun_seen;
	logic [WORD_W-1:0]          lost_total;
	logic [WORD_W-1:0]          overrun_total;

	modport source (output valid, left_sample, right_sample, frame_slot, packet_last,
		packet_sequence, overrun_seen, lost_total, overrun_total, input ready);
	modport sink   (input valid, left_sample, right_sample, frame_slot, packet_last,
		packet_sequence, overrun_seen, lost_total, overrun_total, output ready);
endinterface

### rtl/core/afrp_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module afrp_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data while no read is issued
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/audio_frame_ring_packetizer_core.sv
`timescale 1ns / 1ps
// Audio frame ring packetizer top level.
// Depends on afrp_pkg, afrp_if (channel interfaces) and afrp_ram.
//
// Usage:
//   frame_in carries items with op, left_word and right_word. A capture item
//   (op 0) writes one stereo frame into the 1024-frame ring; a read item (op 1)
//   runs the overrun check and, if a frame is available, sends one result on
//   frame_out with both samples cut to signed 24 bits, the frame slot, the
//   last-of-packet mark, the packet sequence and the running loss totals.
//   Captures and empty reads give no result.
//   Registers are written through wr_en / wr_index / wr_data while idle.
// Timing:
//   One item is accepted per cycle while frame_in.ready is high. A result
//   reaches frame_out through the ring RAM read register and then the output
//   register. Pointers and totals live in flops and are updated in the
//   accept cycle, so back-to-back reads and captures need no interlock.
// Reset:
//   arst_n clears pointers, packet state, totals and valid flags and loads the
//   register defaults. Ring contents are undefined until captured.
// Stall:
//   While frame_out holds a result and a second waits behind it, frame_in.ready
//   drops; the RAM read data holds until the pending result moves on.
module audio_frame_ring_packetizer_core import afrp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	afrp_in_if.sink          frame_in,
	afrp_out_if.source       frame_out,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data
);

	// configuration
	logic [THR_W-1:0] threshold_q;
	logic [REC_W-1:0] recover_q;
	logic [FPP_W-1:0] fpp_q;

	// control state
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  rp_q;
	logic [FPP_W-1:0]  staged_q;
	logic [WORD_W-1:0] seq_q;
	logic [WORD_W-1:0] lost_q;
	logic [WORD_W-1:0] ovr_q;

	// stage 1: waits for ring read data
	logic              valid_s1;
	logic [FPP_W-1:0]  slot_s1;
	logic              last_s1;
	logic [WORD_W-1:0] seq_s1;
	logic              seen_s1;
	logic [WORD_W-1:0] lost_s1;
	logic [WORD_W-1:0] ovr_s1;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;
	logic [FPP_W-1:0]           slot_q;
	logic                       last_q;
	logic [WORD_W-1:0]          seq_out_q;
	logic                       seen_q;
	logic [WORD_W-1:0]          lost_out_q;
	logic [WORD_W-1:0]          ovr_out_q;

	logic               in_ready;
	logic               in_fire;
	logic               cap_fire;
	logic               rd_fire;
	logic [PTR_W-1:0]   avail;
	logic [CNT_W-1:0]   avail_ext;
	logic [CNT_W-1:0]   rec_ext;
	logic [PTR_W-1:0]   rec_mod;
	logic               over;
	logic [PTR_W-1:0]   rd_ptr;
	logic [PTR_W-1:0]   avail_fin;
	logic               emit;
	logic [FPP_W:0]     slot_inc;
	logic               last;
	logic [WORD_W-1:0]  lost_nxt;
	logic [WORD_W-1:0]  ovr_nxt;
	logic [FRAME_W-1:0] ram_rdata;
	logic               out_load;

	assign in_ready = !(valid_s1 && out_valid_q && !frame_out.ready);
	assign in_fire  = frame_in.valid && in_ready;
	assign cap_fire = in_fire && (frame_in.op == OP_CAPTURE);
	assign rd_fire  = in_fire && (frame_in.op == OP_READ);
	assign out_load = valid_s1 && (!out_valid_q || frame_out.ready);

	assign avail     = wp_q - rp_q;
	assign avail_ext = CNT_W'(avail);
	assign rec_ext   = CNT_W'(recover_q);
	assign rec_mod   = rec_ext[PTR_W-1:0];
	assign over      = avail_ext > CNT_W'(threshold_q);
	assign rd_ptr    = over ? (wp_q - rec_mod) : rp_q;
	assign avail_fin = over ? rec_mod : avail;
	assign emit      = rd_fire && (avail_fin != '0);

	assign slot_inc = {1'b0, staged_q} + (FPP_W+1)'(1);
	assign last     = slot_inc >= {1'b0, fpp_q};

	always_comb begin
		lost_nxt = lost_q;
		ovr_nxt  = ovr_q;
		if (over) begin
			ovr_nxt = ovr_q + WORD_W'(1);
			if (avail_ext > rec_ext) begin
				lost_nxt = lost_q + WORD_W'(avail_ext - rec_ext);
			end
		end
	end

	afrp_ram #(
		.WIDTH(FRAME_W),
		.DEPTH(RING_FRAMES)
	) u_ring (
		.clk   (clk),
		.we    (cap_fire),
		.waddr (wp_q),
		.wdata ({frame_in.right_word, frame_in.left_word}),
		.re    (emit),
		.raddr (rd_ptr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			recover_q   <= RECOVER_RESET;
			fpp_q       <= FPP_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_OVERRUN_THRESHOLD: threshold_q <= wr_data[THR_W-1:0];
				REG_RECOVER_FRAMES:    recover_q   <= wr_data[REC_W-1:0];
				REG_FRAMES_PER_PACKET: fpp_q       <= wr_data[FPP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			staged_q <= '0;
			seq_q    <= '0;
			lost_q   <= '0;
			ovr_q    <= '0;
		end else begin
			if (cap_fire) begin
				wp_q <= wp_q + PTR_W'(1);
			end
			if (rd_fire) begin
				lost_q <= lost_nxt;
				ovr_q  <= ovr_nxt;
				rp_q   <= emit ? (rd_ptr + PTR_W'(1)) : rd_ptr;
			end
			if (emit) begin
				if (last) begin
					staged_q <= '0;
					seq_q    <= seq_q + WORD_W'(1);
				end else begin
					staged_q <= slot_inc[FPP_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			slot_s1 <= staged_q;
			last_s1 <= last;
			seq_s1  <= seq_q;
			seen_s1 <= over;
			lost_s1 <= lost_nxt;
			ovr_s1  <= ovr_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || frame_out.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_q     <= ram_rdata[WORD_W-1:SHIFT];
			right_q    <= ram_rdata[FRAME_W-1:WORD_W+SHIFT];
			slot_q     <= slot_s1;
			last_q     <= last_s1;
			seq_out_q  <= seq_s1;
			seen_q     <= seen_s1;
			lost_out_q <= lost_s1;
			ovr_out_q  <= ovr_s1;
		end
	end

	assign frame_in.ready            = in_ready;
	assign frame_out.valid           = out_valid_q;
	assign frame_out.left_sample     = left_q;
	assign frame_out.right_sample    = right_q;
	assign frame_out.frame_slot      = slot_q;
	assign frame_out.packet_last     = last_q;
	assign frame_out.packet_sequence = seq_out_q;
	assign frame_out.overrun_seen    = seen_q;
	assign frame_out.lost_total      = lost_out_q;
	assign frame_out.overrun_total   = ovr_out_q;

endmodule

### rtl/core/afrp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the packetizer top level, attached by bind.
// Depends on afrp_pkg and audio_frame_ring_packetizer_core.
module afrp_checker import afrp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              in_op,
	input logic              out_valid,
	input logic              out_ready,
	input logic [FPP_W-1:0]  out_slot,
	input logic              out_last,
	input logic [WORD_W-1:0] out_seq
);

	logic out_fire;
	assign out_fire = out_valid && out_ready;

	// a stalled result holds its place
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_seq))
		else $error("result changed while stalled");

	// an empty output stage never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// a fresh result comes from a read item accepted earlier, through the ring read stage and the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_op == OP_READ, 2))
		else $error("result without a read item");

	// consecutive results inside one packet share the sequence and step the slot
	a_packet: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && $past(out_fire) && !$past(out_last) |->
			out_seq == $past(out_seq) && out_slot == $past(out_slot) + FPP_W'(1))
		else $error("packet slot or sequence broken");

	// a completed packet moves the sequence on and restarts the slot
	a_next_packet: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && $past(out_fire) && $past(out_last) |->
			out_seq == $past(out_seq) + WORD_W'(1) && out_slot == '0)
		else $error("packet boundary broken");

endmodule

bind audio_frame_ring_packetizer_core afrp_checker u_afrp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frame_in.valid),
	.in_ready  (frame_in.ready),
	.in_op     (frame_in.op),
	.out_valid (frame_out.valid),
	.out_ready (frame_out.ready),
	.out_slot  (frame_out.frame_slot),
	.out_last  (frame_out.packet_last),
	.out_seq   (frame_out.packet_sequence)
);
